// ===== sv/bsm_pkg.sv =====
`timescale 1ns / 1ps

package bsm_pkg;

	// stack size
	localparam int unsigned STACK_DEPTH_DEF = 2048;

	// opcodes
	localparam logic [7:0] OPC_HALT = 8'h00;
	localparam logic [7:0] OPC_PUSH = 8'h01;
	localparam logic [7:0] OPC_POP  = 8'h02;
	localparam logic [7:0] OPC_SUM  = 8'h03;
	localparam logic [7:0] OPC_SUMX = 8'h04;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HALTED    = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	// command word
	typedef struct packed {
		logic [7:0] op;
		logic [7:0] argument;
	} cmd_t;

	// response word
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  top_value;
		logic [11:0] depth;
	} rsp_t;

endpackage

// ===== sv/byte_stack_machine.sv =====
`timescale 1ns / 1ps

// Channel | Handshake             | Word  | Content
// cmd     | cmd_valid / cmd_ready | cmd_t | op, argument
// rsp     | rsp_valid / rsp_ready | rsp_t | status, top_value, depth
//
// Every opcode but sumx with count n > 0: stack RAM read at the accept edge,
// write back and result register as the execute state commits; cmd_ready is
// low in that state, so no new word is taken until it commits. Sumx with
// count n > 0 walks the n operands one per cycle on the single read port, then
// writes the sum back and registers the result as it commits. One word is in
// flight at a time; cmd_ready is high while idle, even when a response still
// waits in the output register. A stalled response holds the finished step until it drains.
// Reset clears depth, top and the stop flag; the stack RAM itself is not cleared.

module byte_stack_machine import bsm_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CW  = (SPW > 8) ? SPW : 8;
	localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SUMX = 3'b100
	} state_t;

	state_t         state_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]     top_q;
	logic           stopped_q;
	logic [7:0]     op_q;
	logic [7:0]     arg_q;
	logic [AW-1:0]  raddr_q;
	logic [AW-1:0]  base_q;
	logic [7:0]     cnt_q;
	logic [7:0]     acc_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic [7:0]     mem [STACK_DEPTH];
	logic [7:0]     rdata_q;

	logic [SPW-1:0] sp_m1;
	logic [SPW-1:0] sp_m2;
	logic [CW-1:0]  base_w;
	logic [AW-1:0]  base_addr;
	logic           sumx_short;
	logic [7:0]     sel_op;
	logic [AW-1:0]  rd_addr;
	logic           out_free;

	logic           commit;
	logic           go_sumx;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic [SPW-1:0] sp_d;
	logic [7:0]     top_d;
	logic           stop_d;
	logic [2:0]     status_d;

	// address arithmetic off the stack pointer
	assign sp_m1      = sp_q - SPW'(1);
	assign sp_m2      = sp_q - SPW'(2);
	assign base_w     = CW'(sp_m1) - CW'(top_q);
	assign base_addr  = base_w[AW-1:0];
	assign sumx_short = CW'(sp_m1) < CW'(top_q);
	assign out_free   = !rsp_valid_q || rsp_ready;

	// read address: operand below top, or sumx base; walk during sumx
	assign sel_op = (state_q == S_IDLE) ? cmd.op : op_q;
	always_comb begin
		rd_addr = sp_m2[AW-1:0];
		unique case (state_q)
			S_IDLE, S_EXEC: begin
				if (sel_op == OPC_SUMX) begin
					rd_addr = base_addr;
				end
			end
			S_SUMX: begin
				rd_addr = raddr_q + AW'(1);
			end
			default: begin
				rd_addr = sp_m2[AW-1:0];
			end
		endcase
	end

	// execute: decide write back, new pointer/top and status
	always_comb begin
		commit   = 1'b0;
		go_sumx  = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = sp_q[AW-1:0];
		wr_data  = arg_q;
		sp_d     = sp_q;
		top_d    = top_q;
		stop_d   = stopped_q;
		status_d = ST_OK;
		unique case (state_q)
			S_EXEC: begin
				if (out_free) begin
					if (stopped_q) begin
						status_d = ST_HALTED;
						commit   = 1'b1;
					end else begin
						unique case (op_q)
							OPC_HALT: begin
								status_d = ST_HALTED;
								stop_d   = 1'b1;
								commit   = 1'b1;
							end
							OPC_PUSH: begin
								commit = 1'b1;
								if (sp_q == SP_FULL) begin
									status_d = ST_OVERFLOW;
								end else begin
									wr_en   = 1'b1;
									wr_addr = sp_q[AW-1:0];
									wr_data = arg_q;
									top_d   = arg_q;
									sp_d    = sp_q + SPW'(1);
								end
							end
							OPC_POP: begin
								commit = 1'b1;
								if (sp_q == '0) begin
									status_d = ST_UNDERFLOW;
								end else begin
									sp_d  = sp_m1;
									top_d = (sp_q >= SPW'(2)) ? rdata_q : 8'd0;
								end
							end
							OPC_SUM: begin
								commit = 1'b1;
								if (sp_q < SPW'(2)) begin
									status_d = ST_UNDERFLOW;
								end else begin
									wr_en   = 1'b1;
									wr_addr = sp_m2[AW-1:0];
									wr_data = rdata_q + top_q;
									top_d   = rdata_q + top_q;
									sp_d    = sp_m1;
								end
							end
							OPC_SUMX: begin
								if (sp_q == '0 || sumx_short) begin
									status_d = ST_UNDERFLOW;
									commit   = 1'b1;
								end else if (top_q == 8'd0) begin
									// zero count: top is replaced by 0
									wr_en   = 1'b1;
									wr_addr = sp_m1[AW-1:0];
									wr_data = 8'd0;
									top_d   = 8'd0;
									commit  = 1'b1;
								end else begin
									go_sumx = 1'b1;
								end
							end
							default: begin
								status_d = ST_UNKNOWN;
								stop_d   = 1'b1;
								commit   = 1'b1;
							end
						endcase
					end
				end
			end
			S_SUMX: begin
				if (cnt_q == 8'd0 && out_free) begin
					wr_en   = 1'b1;
					wr_addr = base_q;
					wr_data = acc_q;
					top_d   = acc_q;
					sp_d    = SPW'(base_q) + SPW'(1);
					commit  = 1'b1;
				end
			end
			S_IDLE: begin
				commit = 1'b0;
			end
			default: begin
				commit = 1'b0;
			end
		endcase
	end

	// stack RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			top_q       <= 8'd0;
			stopped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end else if (go_sumx) begin
						state_q <= S_SUMX;
					end
				end
				S_SUMX: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				sp_q        <= sp_d;
				top_q       <= top_d;
				stopped_q   <= stop_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// word capture, sumx walk and response payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			op_q  <= cmd.op;
			arg_q <= cmd.argument;
		end
		if (go_sumx) begin
			raddr_q <= base_addr;
			base_q  <= base_addr;
			cnt_q   <= top_q;
			acc_q   <= 8'd0;
		end else if (state_q == S_SUMX && cnt_q != 8'd0) begin
			acc_q   <= acc_q + rdata_q;
			cnt_q   <= cnt_q - 8'd1;
			raddr_q <= raddr_q + AW'(1);
		end
		if (commit) begin
			rsp_q.status    <= status_d;
			rsp_q.top_value <= top_d;
			rsp_q.depth     <= 12'(sp_d);
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_FULL)
		else $error("stack pointer beyond stack depth");

	a_top_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q == '0) |-> (top_q == 8'd0))
		else $error("cached top nonzero on empty stack");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop flag cleared");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwrote a pending response");

endmodule
